// File: rtl/rtc_counter_alarm_registers_unit_macros.svh
// ----------------------------------------------------------------------------
// rtc counter alarm registers: assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef RTC_COUNTER_ALARM_REGISTERS_UNIT_MACROS_SVH
`define RTC_COUNTER_ALARM_REGISTERS_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define RTCAR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtcar assertion failed");

`define RTCAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtcar assertion failed");

`define RTCAR_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("rtcar assertion failed");

`else

`define RTCAR_ASSERT_IMP(label, clk, rst, ante, cons)

`define RTCAR_ASSERT_NEXT(label, clk, rst, ante, cons)

`define RTCAR_ASSERT_ALWAYS(label, clk, rst, expr)

`endif

`endif

// File: rtl/rtcar_pkg.sv
// ----------------------------------------------------------------------------
// rtcar_pkg
// shared types and constants of the rtc counter alarm register block
// ----------------------------------------------------------------------------
package rtcar_pkg;

  localparam int COUNTER_BITS  = 47;
  localparam int SECONDS_SHIFT = 15;
  localparam int HIGH_BITS     = 15;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [7:0] OFS_VID      = 8'h00;
  localparam logic [7:0] OFS_FEATURES = 8'h04;
  localparam logic [7:0] OFS_CTRL     = 8'h08;
  localparam logic [7:0] OFS_INT_EN   = 8'h10;
  localparam logic [7:0] OFS_EVENTS   = 8'h14;
  localparam logic [7:0] OFS_PAD_CTRL = 8'h24;
  localparam logic [7:0] OFS_RTC_LS   = 8'h40;
  localparam logic [7:0] OFS_RTC_MS   = 8'h44;
  localparam logic [7:0] OFS_TA       = 8'h50;

  localparam logic [31:0] VID_VALUE      = 32'h0001013e;
  localparam logic [31:0] FEATURES_VALUE = 32'h00000020;
  localparam logic [31:0] CTRL_RESET     = 32'h01000005;
  localparam logic [31:0] INT_EN_RESET   = 32'h00000005;
  localparam logic [31:0] EVENTS_RESET   = 32'h00000005;

  localparam logic [1:0] ENABLE_ON = 2'b10;
  localparam int         ALARM_BIT = 3;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  address;
    logic [31:0] write_data;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        interrupt;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } exec_t;

endpackage

// File: rtl/rtcar_core.sv
// ----------------------------------------------------------------------------
// rtcar_core
// register file, tick counter and alarm; executes one item per cycle
// ----------------------------------------------------------------------------
`include "rtc_counter_alarm_registers_unit_macros.svh"

module rtcar_core (
  input  logic             clk,
  input  logic             rst,
  input  rtcar_pkg::exec_t exec,
  output rtcar_pkg::result_t res
);
  import rtcar_pkg::*;

  logic [31:0]             control_reg;
  logic [31:0]             interrupt_enable_reg;
  logic [31:0]             event_flags;
  logic [31:0]             pad_control_reg;
  logic [31:0]             alarm_seconds;
  logic [31:0]             staged_low;
  logic [HIGH_BITS-1:0]    staged_high;
  logic                    time_set_pending;
  logic [COUNTER_BITS-1:0] tick_counter;
  logic                    alarm_armed;

  logic [31:0]             control_reg_next;
  logic [31:0]             interrupt_enable_reg_next;
  logic [31:0]             event_flags_next;
  logic [31:0]             pad_control_reg_next;
  logic [31:0]             alarm_seconds_next;
  logic [31:0]             staged_low_next;
  logic [HIGH_BITS-1:0]    staged_high_next;
  logic                    time_set_pending_next;
  logic [COUNTER_BITS-1:0] tick_counter_next;
  logic                    alarm_armed_next;

  logic [31:0] read_value;
  logic [63:0] counter_wide;
  logic [63:0] alarm_target;

  assign counter_wide = 64'(tick_counter);

  // register read decode
  always_comb begin
    unique case (exec.item.address)
      OFS_VID:      read_value = VID_VALUE;
      OFS_FEATURES: read_value = FEATURES_VALUE;
      OFS_CTRL:     read_value = control_reg;
      OFS_INT_EN:   read_value = interrupt_enable_reg;
      OFS_EVENTS:   read_value = event_flags;
      OFS_PAD_CTRL: read_value = pad_control_reg;
      OFS_RTC_LS:   read_value = counter_wide[31:0];
      OFS_RTC_MS:   read_value = 32'(counter_wide[32 +: HIGH_BITS]);
      OFS_TA:       read_value = alarm_seconds;
      default:      read_value = '0;
    endcase
  end

  always_comb begin
    control_reg_next          = control_reg;
    interrupt_enable_reg_next = interrupt_enable_reg;
    event_flags_next          = event_flags;
    pad_control_reg_next      = pad_control_reg;
    alarm_seconds_next        = alarm_seconds;
    staged_low_next           = staged_low;
    staged_high_next          = staged_high;
    time_set_pending_next     = time_set_pending;
    tick_counter_next         = tick_counter;
    alarm_armed_next          = alarm_armed;
    res.read_data             = '0;

    case (exec.item.action)
      ACT_READ: begin
        res.read_data = read_value;
      end
      ACT_WRITE: begin
        unique case (exec.item.address)
          OFS_CTRL: begin
            if (exec.item.write_data[1:0] == ENABLE_ON &&
                control_reg[1:0] != ENABLE_ON && time_set_pending) begin
              tick_counter_next     = COUNTER_BITS'({staged_high, staged_low});
              time_set_pending_next = 1'b0;
            end
            control_reg_next = exec.item.write_data;
            alarm_armed_next = exec.item.write_data[ALARM_BIT];
          end
          OFS_INT_EN:   interrupt_enable_reg_next = exec.item.write_data;
          OFS_EVENTS:   event_flags_next = event_flags & ~exec.item.write_data;
          OFS_PAD_CTRL: pad_control_reg_next = exec.item.write_data;
          OFS_RTC_LS: begin
            staged_low_next       = exec.item.write_data;
            time_set_pending_next = 1'b1;
          end
          OFS_RTC_MS: begin
            staged_high_next      = exec.item.write_data[HIGH_BITS-1:0];
            time_set_pending_next = 1'b1;
          end
          OFS_TA: begin
            alarm_seconds_next = exec.item.write_data;
            alarm_armed_next   = control_reg[ALARM_BIT];
          end
          default: ;
        endcase
      end
      ACT_TICK: begin
        tick_counter_next = tick_counter + COUNTER_BITS'(1);
      end
      default: ;
    endcase

    // alarm check after the item
    alarm_target = 64'(alarm_seconds_next) << SECONDS_SHIFT;
    if (alarm_armed_next && 64'(tick_counter_next) >= alarm_target) begin
      event_flags_next[ALARM_BIT] = 1'b1;
      alarm_armed_next            = 1'b0;
    end

    res.interrupt = event_flags_next[ALARM_BIT] & interrupt_enable_reg_next[ALARM_BIT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg          <= CTRL_RESET;
      interrupt_enable_reg <= INT_EN_RESET;
      event_flags          <= EVENTS_RESET;
      pad_control_reg      <= '0;
      alarm_seconds        <= '0;
      staged_low           <= '0;
      staged_high          <= '0;
      time_set_pending     <= 1'b0;
      tick_counter         <= '0;
      alarm_armed          <= 1'b0;
    end else if (exec.valid) begin
      control_reg          <= control_reg_next;
      interrupt_enable_reg <= interrupt_enable_reg_next;
      event_flags          <= event_flags_next;
      pad_control_reg      <= pad_control_reg_next;
      alarm_seconds        <= alarm_seconds_next;
      staged_low           <= staged_low_next;
      staged_high          <= staged_high_next;
      time_set_pending     <= time_set_pending_next;
      tick_counter         <= tick_counter_next;
      alarm_armed          <= alarm_armed_next;
    end
  end

  `RTCAR_ASSERT_NEXT(a_disarm_on_ctrl, clk, rst,
    exec.valid && exec.item.action == ACT_WRITE && exec.item.address == OFS_CTRL &&
    !exec.item.write_data[ALARM_BIT], !alarm_armed)
  `RTCAR_ASSERT_NEXT(a_counter_idle, clk, rst, !exec.valid, $stable(tick_counter))
  `RTCAR_ASSERT_IMP(a_event_from_alarm, clk, rst, $rose(event_flags[ALARM_BIT]),
    $past(alarm_armed) || $past(exec.item.address) == OFS_CTRL ||
    $past(exec.item.address) == OFS_TA)

endmodule

// File: rtl/rtcar_out_buf.sv
// ----------------------------------------------------------------------------
// rtcar_out_buf
// two-entry result queue between the core and the result channel
// ----------------------------------------------------------------------------
`include "rtc_counter_alarm_registers_unit_macros.svh"

module rtcar_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rtcar_pkg::result_t push_data,
  output logic               full,
  output logic               result_valid,
  input  logic               result_stall,
  output rtcar_pkg::result_t result
);
  import rtcar_pkg::*;

  result_t    slots [2];
  logic       head;
  logic [1:0] count;
  logic       tail;
  logic       pop;

  assign full         = (count == 2'd2);
  assign result_valid = (count != 2'd0);
  assign result       = slots[head];
  assign tail         = head ^ count[0];
  assign pop          = result_valid & ~result_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= ~head;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `RTCAR_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= 2'd2)

endmodule

// File: rtl/rtc_counter_alarm_registers_unit.sv
// ----------------------------------------------------------------------------
// rtc_counter_alarm_registers_unit
// rtc register block with wrapping tick counter and one-shot seconds alarm
// ----------------------------------------------------------------------------
// items are registered at the input and run by the core while the result queue
// has room, one item per cycle; each result is registered in the queue, and
// its two entries let items keep flowing while a result is stalled
// reset: synchronous, active high; registers take their documented reset values
// ----------------------------------------------------------------------------
module rtc_counter_alarm_registers_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  rtcar_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output rtcar_pkg::result_t result
);
  import rtcar_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    full;
  exec_t   exec;
  result_t core_res;

  assign item_stall = in_valid & full;
  assign exec.valid = in_valid & ~full;
  assign exec.item  = in_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_valid <= 1'b1;
    end else if (exec.valid) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_item <= item;
    end
  end

  rtcar_core u_core (
    .clk  (clk),
    .rst  (rst),
    .exec (exec),
    .res  (core_res)
  );

  rtcar_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (exec.valid),
    .push_data    (core_res),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
